// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the particle update block.
// Depends on nothing; each user must have signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define VV_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define VV_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/vvpu_pkg.sv
// Types, constants and saturation helpers of the particle update block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vvpu_pkg;

   localparam int DataW    = 32;
   localparam int NumComp  = 3;
   localparam int TypeRegs = 3;
   localparam int NumW     = 2 * DataW;
   localparam int QuoW     = 34;               // quotient bits kept; larger saturates anyway
   localparam int DivSteps = QuoW;
   localparam int DivLat   = DivSteps + 1;
   localparam int QDepth   = 2;
   localparam int IdxW     = 3;
   localparam int TypeW    = 2;
   localparam logic [DataW-1:0] MassOne = 32'h0001_0000;

   typedef enum logic [IdxW-1:0] {
      REG_POS_STEP    = 3'd0,
      REG_VEL_STEP    = 3'd1,
      REG_GROUP_SEL   = 3'd2,
      REG_MASS_MODE   = 3'd3,
      REG_PHASE       = 3'd4,
      REG_TYPE_MASS_0 = 3'd5,
      REG_TYPE_MASS_1 = 3'd6,
      REG_TYPE_MASS_2 = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [DataW-1:0]                   pos_step;
      logic [DataW-1:0]                   vel_step;
      logic [DataW-1:0]                   group_select;
      logic                               mass_mode;
      logic                               phase;
      logic [TypeRegs-1:0][DataW-1:0]     type_mass;
   } cfg_type;

   // Classified particle as handed from front to back
   typedef struct packed {
      logic                               upd;
      logic                               err;
      logic [DataW-1:0]                   mass;
      logic [NumComp-1:0]                 fneg;
      logic [NumComp-1:0][NumW-1:0]       num;
      logic [NumComp-1:0][DataW-1:0]      vel;
      logic [NumComp-1:0][DataW-1:0]      pos;
   } item_type;

   // What rides alongside the divider
   typedef struct packed {
      logic                               upd;
      logic                               err;
      logic [NumComp-1:0]                 fneg;
      logic [NumComp-1:0][DataW-1:0]      vel;
      logic [NumComp-1:0][DataW-1:0]      pos;
   } side_type;

   typedef struct packed {
      logic                               full;
      logic                               empty;
      logic [1:0]                         count;
   } qstat_type;

   // Clamp a 37-bit signed sum to signed 32 bits
   function automatic logic [DataW-1:0] sat37(input logic signed [36:0] s);
      logic [DataW-1:0] r;
      if (s[36:31] == 6'b000000 || s[36:31] == 6'b111111) r = s[31:0];
      else if (s[36]) r = 32'h8000_0000;
      else r = 32'h7fff_ffff;
      return r;
   endfunction

   // Clamp a 50-bit signed sum to signed 32 bits
   function automatic logic [DataW-1:0] sat50(input logic signed [49:0] s);
      logic [DataW-1:0] r;
      if (s[49:31] == '0 || s[49:31] == '1) r = s[31:0];
      else if (s[49]) r = 32'h8000_0000;
      else r = 32'h7fff_ffff;
      return r;
   endfunction

   function automatic logic [DataW-1:0] magn(input logic [DataW-1:0] x);
      return x[DataW-1] ? (~x + 32'd1) : x;
   endfunction

endpackage

// File: hw/rtl/vvpu_front.sv
// Front end: accepts particles, checks group, picks the mass, forms |force|*vel_step.
// Depends on vvpu_pkg.
`timescale 1ns / 1ps

module vvpu_front #(
   parameter int NUM_TYPES = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [vvpu_pkg::DataW-1:0]             group_bits,
   input  logic [vvpu_pkg::TypeW-1:0]             particle_type,
   input  logic [vvpu_pkg::DataW-1:0]             own_mass,
   input  logic [vvpu_pkg::NumComp-1:0][vvpu_pkg::DataW-1:0] force_v,
   input  logic [vvpu_pkg::NumComp-1:0][vvpu_pkg::DataW-1:0] vel_v,
   input  logic [vvpu_pkg::NumComp-1:0][vvpu_pkg::DataW-1:0] pos_v,
   input  vvpu_pkg::cfg_type                      cfg,
   input  logic                                   q_full,
   output logic                                   out_valid,
   output vvpu_pkg::item_type                     out_item
);
   import vvpu_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     take, push, sel, type_ok;
   logic [DataW-1:0] mass;

   assign in_ready = !valid_ff || !q_full;
   assign take     = in_valid && in_ready;
   assign push     = valid_ff && !q_full;

   // classify the incoming particle
   always_comb begin
      sel     = |(group_bits & cfg.group_select);
      type_ok = 32'(particle_type) < NUM_TYPES;
      if (cfg.mass_mode) mass = own_mass;
      else if (type_ok) mass = cfg.type_mass[particle_type];
      else mass = '0;
      item_in.upd  = sel && (mass != '0);
      item_in.err  = sel && (mass == '0);
      item_in.mass = mass;
      item_in.vel  = vel_v;
      item_in.pos  = pos_v;
      for (int k = 0; k < NumComp; k++) begin
         item_in.fneg[k] = force_v[k][DataW-1];
         item_in.num[k]  = NumW'(cfg.vel_step) * NumW'(magn(force_v[k]));
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) valid_in = 1'b1;
      else if (push) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (take) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// File: hw/rtl/vvpu_queue.sv
// Two-entry queue between the front end and the arithmetic back end.
// Depends on vvpu_pkg.
`timescale 1ns / 1ps

module vvpu_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vvpu_pkg::item_type   push_item,
   input  logic                 pop,
   output vvpu_pkg::item_type   head,
   output vvpu_pkg::qstat_type  stat
);
   import vvpu_pkg::*;

   item_type   mem_ff [0:QDepth-1];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ pop;
      cnt_in  = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_item;
   end

   assign head       = mem_ff[rptr_ff];
   assign stat.count = cnt_ff;
   assign stat.full  = cnt_ff == 2'(QDepth);
   assign stat.empty = cnt_ff == '0;

endmodule

// File: hw/rtl/vvpu_div.sv
// Pipelined restoring divider: one quotient bit per stage, flags quotients too large.
// Depends on vvpu_pkg.
`timescale 1ns / 1ps

module vvpu_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [vvpu_pkg::NumW-1:0]     num,
   input  logic [vvpu_pkg::DataW-1:0]    den,
   output logic [vvpu_pkg::QuoW-1:0]     quo,
   output logic                          ovf
);
   import vvpu_pkg::*;

   localparam int HiW = NumW - QuoW;

   logic [DataW-1:0] rem_ff [0:DivSteps];
   logic [QuoW-1:0]  low_ff [0:DivSteps];
   logic [QuoW-1:0]  quo_ff [0:DivSteps];
   logic [DataW-1:0] den_ff [0:DivSteps];
   logic             ovf_ff [0:DivSteps];
   logic [DataW-1:0] hi;

   assign hi = {{(DataW-HiW){1'b0}}, num[NumW-1:QuoW]};

   // entry stage: upper bits form the first partial remainder
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= hi;
         low_ff[0] <= num[QuoW-1:0];
         quo_ff[0] <= '0;
         den_ff[0] <= den;
         ovf_ff[0] <= hi >= den;
      end
   end

   for (genvar k = 0; k < DivSteps; k++) begin : g_step
      logic [DataW:0]   t, diff;
      logic             ge;
      logic [DataW-1:0] rem_in;
      logic [QuoW-1:0]  quo_in;

      always_comb begin
         t      = {rem_ff[k], low_ff[k][QuoW-1]};
         diff   = t - {1'b0, den_ff[k]};
         ge     = t >= {1'b0, den_ff[k]};
         rem_in = ge ? diff[DataW-1:0] : t[DataW-1:0];
         quo_in = {quo_ff[k][QuoW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= rem_in;
            low_ff[k+1] <= {low_ff[k][QuoW-2:0], 1'b0};
            quo_ff[k+1] <= quo_in;
            den_ff[k+1] <= den_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
         end
      end
   end

   assign quo = quo_ff[DivSteps];
   assign ovf = ovf_ff[DivSteps];

endmodule

// File: hw/rtl/vvpu_back.sv
// Back end: force/mass divide, velocity update, position update, result register.
// Depends on vvpu_pkg and vvpu_div.
`timescale 1ns / 1ps

module vvpu_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  vvpu_pkg::item_type                 in_item,
   input  vvpu_pkg::cfg_type                  cfg,
   output logic                               out_valid,
   output logic [vvpu_pkg::NumComp-1:0][vvpu_pkg::DataW-1:0] out_vel,
   output logic [vvpu_pkg::NumComp-1:0][vvpu_pkg::DataW-1:0] out_pos,
   output logic                               out_upd,
   output logic                               out_err
);
   import vvpu_pkg::*;

   // side pipe matching the divider latency
   side_type side_ff [0:DivLat-1];
   logic     sv_ff   [0:DivLat-1];
   side_type side_in;

   logic [NumComp-1:0][QuoW-1:0] quo;
   logic [NumComp-1:0]           ovf;

   for (genvar k = 0; k < NumComp; k++) begin : g_lane
      vvpu_div u_div (
         .clock (clock),
         .en    (en),
         .num   (in_item.num[k]),
         .den   (in_item.mass),
         .quo   (quo[k]),
         .ovf   (ovf[k])
      );
   end

   always_comb begin
      side_in.upd  = in_item.upd;
      side_in.err  = in_item.err;
      side_in.fneg = in_item.fneg;
      side_in.vel  = in_item.vel;
      side_in.pos  = in_item.pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DivLat; i++) sv_ff[i] <= 1'b0;
      end else if (en) begin
         sv_ff[0] <= in_valid;
         for (int i = 1; i < DivLat; i++) sv_ff[i] <= sv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < DivLat; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // stage A: velocity add with saturation
   side_type a_ff, a_in;
   logic     av_ff;

   always_comb begin
      logic [QuoW:0]         d;
      logic signed [36:0]    dv, s;
      a_in = side_ff[DivLat-1];
      for (int k = 0; k < NumComp; k++) begin
         d  = ovf[k] ? (QuoW+1)'(1) << QuoW : {1'b0, quo[k]};
         dv = side_ff[DivLat-1].fneg[k] ? -$signed(37'(d)) : $signed(37'(d));
         s  = $signed({{5{side_ff[DivLat-1].vel[k][DataW-1]}}, side_ff[DivLat-1].vel[k]}) + dv;
         if (side_ff[DivLat-1].upd) a_in.vel[k] = sat37(s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) av_ff <= 1'b0;
      else if (en) av_ff <= sv_ff[DivLat-1];
   end

   always_ff @(posedge clock) begin
      if (en) a_ff <= a_in;
   end

   // stage B: |new velocity| times position step
   side_type                     b_ff;
   logic                         bv_ff;
   logic [NumComp-1:0][NumW-1:0] prod_ff, prod_in;

   always_comb begin
      for (int k = 0; k < NumComp; k++)
         prod_in[k] = NumW'(cfg.pos_step) * NumW'(magn(a_ff.vel[k]));
   end

   always_ff @(posedge clock) begin
      if (reset) bv_ff <= 1'b0;
      else if (en) bv_ff <= av_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff    <= a_ff;
         prod_ff <= prod_in;
      end
   end

   // stage C: position add with saturation, result register
   logic [NumComp-1:0][DataW-1:0] pos_in;

   always_comb begin
      logic [47:0]        p;
      logic signed [49:0] dp, s;
      pos_in = b_ff.pos;
      for (int k = 0; k < NumComp; k++) begin
         p  = prod_ff[k][NumW-1:16];
         dp = b_ff.vel[k][DataW-1] ? -$signed({2'b00, p}) : $signed({2'b00, p});
         s  = $signed({{18{b_ff.pos[k][DataW-1]}}, b_ff.pos[k]}) + dp;
         if (b_ff.upd && !cfg.phase) pos_in[k] = sat50(s);
      end
   end

   logic                          ov_ff;
   logic [NumComp-1:0][DataW-1:0] ovel_ff, opos_ff;
   logic                          oupd_ff, oerr_ff;

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (en) ov_ff <= bv_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovel_ff <= b_ff.vel;
         opos_ff <= pos_in;
         oupd_ff <= b_ff.upd;
         oerr_ff <= b_ff.err;
      end
   end

   assign out_valid = ov_ff;
   assign out_vel   = ovel_ff;
   assign out_pos   = opos_ff;
   assign out_upd   = oupd_ff;
   assign out_err   = oerr_ff;

endmodule

// File: hw/rtl/velocity_verlet_particle_update.sv
// Channel  | Handshake           | Payload
// req      | req_tvalid/tready   | tdata: particle fields, tuser: particle_type
// rsp      | rsp_tvalid/tready   | tdata: new velocity and position, tuser: flags
// csr      | csr_valid/csr_ready | csr_index, csr_data (always ready)
//
// One particle per cycle unless rsp stalls; rsp_tvalid rises once the req transaction
// has passed the front register, queue entry, divider entry stage plus 34 quotient-bit
// stages, three arithmetic stages (velocity add, position product, position add/result).
// Synchronous active-high reset clears control state; registers take their defaults.
// A stalled rsp freezes the back pipeline; the two queue entries and the front register
// hold up to three transactions before req_tready drops.
// Depends on vvpu_pkg, vvpu_front, vvpu_queue, vvpu_back and assert_macros.svh.
`timescale 1ns / 1ps

module velocity_verlet_particle_update #(
   parameter int NUM_TYPES = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // group_bits, own_mass, force_x/y/z, vel_x/y/z, pos_x/y/z (32 bits each)
   input  logic [351:0] req_tdata,
   // particle_type
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_vel_x/y/z, new_pos_x/y/z (32 bits each)
   output logic [191:0] rsp_tdata,
   // was_updated, mass_error
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);
   import vvpu_pkg::*;

   `include "assert_macros.svh"

   // configuration registers
   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            REG_POS_STEP:    cfg_in.pos_step     = csr_data;
            REG_VEL_STEP:    cfg_in.vel_step     = csr_data;
            REG_GROUP_SEL:   cfg_in.group_select = csr_data;
            REG_MASS_MODE:   cfg_in.mass_mode    = csr_data[0];
            REG_PHASE:       cfg_in.phase        = csr_data[0];
            REG_TYPE_MASS_0: cfg_in.type_mass[0] = csr_data;
            REG_TYPE_MASS_1: cfg_in.type_mass[1] = csr_data;
            REG_TYPE_MASS_2: cfg_in.type_mass[2] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pos_step     <= '0;
         cfg_ff.vel_step     <= '0;
         cfg_ff.group_select <= '0;
         cfg_ff.mass_mode    <= 1'b0;
         cfg_ff.phase        <= 1'b0;
         for (int i = 0; i < TypeRegs; i++) cfg_ff.type_mass[i] <= MassOne;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // unpack request
   logic [NumComp-1:0][DataW-1:0] force_v, vel_v, pos_v;

   always_comb begin
      for (int k = 0; k < NumComp; k++) begin
         force_v[k] = req_tdata[64 + 32*k +: 32];
         vel_v[k]   = req_tdata[160 + 32*k +: 32];
         pos_v[k]   = req_tdata[256 + 32*k +: 32];
      end
   end

   logic      front_valid, q_pop, back_en;
   item_type  front_item, q_head;
   qstat_type q_stat;

   vvpu_front #(.NUM_TYPES(NUM_TYPES)) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .group_bits    (req_tdata[31:0]),
      .particle_type (req_tuser),
      .own_mass      (req_tdata[63:32]),
      .force_v       (force_v),
      .vel_v         (vel_v),
      .pos_v         (pos_v),
      .cfg           (cfg_ff),
      .q_full        (q_stat.full),
      .out_valid     (front_valid),
      .out_item      (front_item)
   );

   assign back_en = !rsp_tvalid || rsp_tready;
   assign q_pop   = back_en && !q_stat.empty;

   vvpu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid && !q_stat.full),
      .push_item (front_item),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   logic [NumComp-1:0][DataW-1:0] new_vel, new_pos;

   vvpu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (back_en),
      .in_valid  (!q_stat.empty),
      .in_item   (q_head),
      .cfg       (cfg_ff),
      .out_valid (rsp_tvalid),
      .out_vel   (new_vel),
      .out_pos   (new_pos),
      .out_upd   (rsp_tuser[0]),
      .out_err   (rsp_tuser[1])
   );

   always_comb begin
      for (int k = 0; k < NumComp; k++) begin
         rsp_tdata[32*k +: 32]      = new_vel[k];
         rsp_tdata[96 + 32*k +: 32] = new_pos[k];
      end
   end

   // checks
   `VV_ASSERT_NOW(a_flags_excl, rsp_tvalid, !(rsp_tuser[0] && rsp_tuser[1]))
   `VV_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= 2'(QDepth))
   `VV_ASSERT_NOW(a_front_bp, front_valid && q_stat.full, !req_tready)

endmodule

// File: dv/velocity_verlet_particle_update_tb.sv
// Self-checking testbench for velocity_verlet_particle_update.
// Drives particles and register writes and checks every result against a
// predictor in this file. Needs only the RTL and vvpu_pkg.
`timescale 1ns / 1ps

module velocity_verlet_particle_update_tb;
   import vvpu_pkg::*;

   typedef struct packed {
      logic [2:0][31:0] x;
      logic [2:0][31:0] v;
      logic [2:0][31:0] f;
      logic [31:0]      own;
      logic [31:0]      grp;
      logic [1:0]       ptype;
   } particle_type;

   typedef struct packed {
      logic [2:0][31:0] x;
      logic [2:0][31:0] v;
      logic             err;
      logic             upd;
   } update_type;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [351:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [191:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         csr_valid = 0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_data = '0;

   // Predictor copy of the registers
   logic [31:0] m_pos_step, m_vel_step, m_group_sel;
   logic        m_mass_mode, m_phase;
   logic [31:0] m_type_mass [3];

   particle_type pending_particles[$];
   update_type   expected_updates[$];
   int        mismatches = 0;
   int        rsp_count = 0;
   int        idle_cycles = 0;
   bit        quiet = 0;
   int        req_gap = 0, rsp_gap = 0, hold_left = 0;
   bit        held = 0;

   velocity_verlet_particle_update dut (.*);

   always #5 clock = ~clock;

   function automatic longint clamp32(longint s);
      if (s > 64'sd2147483647) return 64'sd2147483647;
      if (s < -64'sd2147483648) return -64'sd2147483648;
      return s;
   endfunction

   // Magnitude capped at 2^40, then signed
   function automatic longint capped(logic [63:0] m, bit neg);
      if (m > 64'd1 << 40) m = 64'd1 << 40;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   function automatic update_type integrate(particle_type p);
      update_type  r;
      logic [31:0] mass;
      logic [63:0] mg, num;
      longint      fv, vv, xv;
      mass = '0;
      r.upd = 0;
      r.err = 0;
      r.v = p.v;
      r.x = p.x;
      if ((p.grp & m_group_sel) != 0) begin
         if (m_mass_mode) mass = p.own;
         else if (p.ptype < 3) mass = m_type_mass[p.ptype];
         if (mass == 0) begin
            r.err = 1;
         end else begin
            r.upd = 1;
            for (int k = 0; k < 3; k++) begin
               fv = longint'($signed(p.f[k]));
               vv = longint'($signed(p.v[k]));
               mg = fv < 0 ? -fv : fv;
               num = {32'b0, m_vel_step} * mg;
               vv = clamp32(vv + capped(num / {32'b0, mass}, fv < 0));
               r.v[k] = vv[31:0];
               if (!m_phase) begin
                  xv = longint'($signed(p.x[k]));
                  mg = vv < 0 ? -vv : vv;
                  num = ({32'b0, m_pos_step} * mg) >> 16;
                  xv = clamp32(xv + capped(num, vv < 0));
                  r.x[k] = xv[31:0];
               end
            end
         end
      end
      return r;
   endfunction

   // Request side: present the head of the queue, random bursts of idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_gap <= 0;
      end else begin
         if (req_tvalid && req_tready)
            expected_updates.push_back(integrate(pending_particles.pop_front()));
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1;
         end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 0;
         end else if (!quiet && pending_particles.size() > 0 &&
                      $urandom_range(0, 15) == 0) begin
            req_gap <= $urandom_range(0, 11);
            req_tvalid <= 0;
         end else if (pending_particles.size() > 0) begin
            req_tvalid <= 1;
            req_tdata <= {pending_particles[0].x, pending_particles[0].v,
                          pending_particles[0].f, pending_particles[0].own,
                          pending_particles[0].grp};
            req_tuser <= pending_particles[0].ptype;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // Response side: compare each transaction, random stalls and one long hold
   always @(posedge clock) begin
      update_type got, want;
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            got = {rsp_tdata, rsp_tuser};
            if (expected_updates.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected result %h", got);
            end else begin
               want = expected_updates.pop_front();
               if (got.v !== want.v || got.x !== want.x ||
                   got.upd !== want.upd || got.err !== want.err) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display(
                        "mismatch: vel %h pos %h upd %b err %b, exp vel %h pos %h upd %b err %b",
                        got.v, got.x, got.upd, got.err,
                        want.v, want.x, want.upd, want.err);
               end
            end
         end
         if (!held && rsp_count == 200) begin
            held <= 1;
            hold_left <= 300;
            rsp_tready <= 0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 0;
         end else if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_tready <= 0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_gap <= $urandom_range(0, 11);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("velocity_verlet_particle_update_tb: done, errors");
         $finish;
      end
   end

   task automatic write_reg(csr_idx_type idx, logic [31:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         REG_POS_STEP:    m_pos_step = d;
         REG_VEL_STEP:    m_vel_step = d;
         REG_GROUP_SEL:   m_group_sel = d;
         REG_MASS_MODE:   m_mass_mode = d[0];
         REG_PHASE:       m_phase = d[0];
         REG_TYPE_MASS_0: m_type_mass[0] = d;
         REG_TYPE_MASS_1: m_type_mass[1] = d;
         REG_TYPE_MASS_2: m_type_mass[2] = d;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Corner values mixed into random data
   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 9))
         0: return 32'h0;
         1: return 32'hffff_ffff;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         4, 5: return $urandom_range(0, 32'h3_ffff);
         6: return -$urandom_range(0, 32'h3_ffff);
         default: return $urandom;
      endcase
   endfunction

   function automatic particle_type random_particle();
      particle_type p;
      p.grp = pick32();
      if ($urandom_range(0, 4) != 0) p.grp |= m_group_sel & $urandom;
      if ($urandom_range(0, 2) != 0) p.grp |= m_group_sel;
      p.ptype = $urandom_range(0, 7) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
      p.own = $urandom_range(0, 15) == 0 ? 32'h0 : pick32();
      for (int k = 0; k < 3; k++) begin
         p.f[k] = pick32();
         p.v[k] = pick32();
         p.x[k] = pick32();
      end
      return p;
   endfunction

   task automatic run_phase(logic [31:0] ps, vs, gs, logic mm, ph,
                            logic [31:0] m0, m1, m2, int count);
      wait (pending_particles.size() == 0 && expected_updates.size() == 0);
      repeat (50) @(posedge clock);
      write_reg(REG_POS_STEP, ps);
      write_reg(REG_VEL_STEP, vs);
      write_reg(REG_GROUP_SEL, gs);
      write_reg(REG_MASS_MODE, {31'b0, mm});
      write_reg(REG_PHASE, {31'b0, ph});
      write_reg(REG_TYPE_MASS_0, m0);
      write_reg(REG_TYPE_MASS_1, m1);
      write_reg(REG_TYPE_MASS_2, m2);
      repeat (count) pending_particles.push_back(random_particle());
   endtask

   initial begin
      particle_type p;
      m_pos_step = 0;
      m_vel_step = 0;
      m_group_sel = 0;
      m_mass_mode = 0;
      m_phase = 0;
      foreach (m_type_mass[i]) m_type_mass[i] = 32'h1_0000;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: table mode, type 2 has zero mass
      run_phase(32'h8000, 32'h1_0000, 32'hffff_ffff, 0, 0,
                32'h1_0000, 32'h2_0000, 32'h0, 0);
      for (int i = 0; i < 20; i++) begin
         p.grp = 32'hffff_ffff;
         p.ptype = 2'(i % 4);      // type 3 is out of range: mass error
         p.own = i[0] ? 32'h0 : 32'hffff_ffff;
         for (int k = 0; k < 3; k++) begin
            p.f[k] = (i % 5 == 0) ? 32'h7fff_ffff : (i % 5 == 1) ? 32'h8000_0000 :
                     (i % 5 == 2) ? 32'h0 : 32'h0001_8000 * (k + 1);
            p.v[k] = (i < 8) ? 32'h7fff_ffff - k : (i < 14) ? 32'h8000_0000 + k
                                                             : -32'h0002_0000;
            p.x[k] = i[1] ? 32'h8000_0000 : 32'h7fff_fff0;
         end
         if (i == 19) p.grp = 32'h0;  // not in any selected group
         pending_particles.push_back(p);
      end

      // Random: several register settings, extremes among them
      run_phase(32'hffff_ffff, 32'hffff_ffff, $urandom, 1, 0,
                32'hffff_ffff, 32'h1, $urandom, 200);
      run_phase(32'h0, 32'h0, 32'h0, 0, 1, 32'h0, 32'h0, 32'h0, 100);
      run_phase($urandom, 32'h100, 32'hffff_ffff, 1, 1,
                $urandom, $urandom, $urandom, 200);
      run_phase(32'h800, 32'h8000, 32'h0000_00ff, 0, 0,
                32'h1, 32'hffff_ffff, 32'h3_0000, 200);
      run_phase($urandom, $urandom, $urandom, 1, 0,
                $urandom, $urandom, $urandom, 200);
      quiet = 1;
      run_phase(32'h1_0000, 32'h4000, 32'hffff_ffff, 0, 0,
                32'h2_0000, 32'h0, 32'h8000, 230);

      wait (pending_particles.size() == 0 && expected_updates.size() == 0);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && expected_updates.size() == 0)
         $display("velocity_verlet_particle_update_tb: done, clean");
      else
         $display("velocity_verlet_particle_update_tb: done, errors");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/vvpu_pkg.sv
hw/rtl/vvpu_front.sv
hw/rtl/vvpu_queue.sv
hw/rtl/vvpu_div.sv
hw/rtl/vvpu_back.sv
hw/rtl/velocity_verlet_particle_update.sv
dv/velocity_verlet_particle_update_tb.sv
